### sv/gcd_pkg.sv
package gcd_pkg;

   localparam int CORDIC_STAGES_DEF = 32;

   // field widths
   localparam int LAT_W  = 31;
   localparam int LON_W  = 32;
   localparam int ANG_W  = 32;
   localparam int DIST_W = 35;
   localparam int CSR_W  = 32;

   // angle reduction, 1e-7 degree units
   localparam int RED_W     = 34;
   localparam int RED_OUT_W = 31;
   localparam logic signed [RED_W-1:0] FULL_TURN    = 34'sd3600000000;
   localparam logic signed [RED_W-1:0] HALF_TURN    = 34'sd1800000000;
   localparam logic signed [RED_W-1:0] QUARTER_TURN = 34'sd900000000;
   localparam logic [32:0]             DEG7_TO_RAD_Q31 = 33'd4024455254;

   // CORDIC datapath, Q4.30
   localparam int CW = 34;
   localparam int ZW = 34;
   localparam logic signed [CW-1:0] INV_GAIN    = 34'sd652032874;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [31:0] ATAN_HEAD [10] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149
   };

   // dot product and root
   localparam int DOT_W    = 32;
   localparam int SQ_STEPS = 32;
   localparam int SQ_W     = 2 * SQ_STEPS - 1;
   localparam int SQRT_W   = 31;
   localparam int ACOS_W   = 32;

   // scaling to millimetres
   localparam logic [32:0]       RADIUS_MM    = 33'd6378137000;
   localparam logic [DIST_W-1:0] HALF_CIRC_MM = 35'd20037508343;

   localparam logic signed [LAT_W-1:0] TARGET_LAT_RST = 31'sd408797150;
   localparam logic signed [LON_W-1:0] TARGET_LON_RST = -32'sd1191217680;

   typedef enum logic [0:0] {
      CSR_TARGET_LAT = 1'b0,
      CSR_TARGET_LON = 1'b1
   } csr_index_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] v;
      if (i < 10) begin
         v = ZW'(ATAN_HEAD[i]);
      end else if (i <= 30) begin
         v = ZW'((64'd1 << (30 - i)) - 64'd1);
      end else begin
         v = '0;
      end
      return v;
   endfunction

endpackage

### sv/gcd_sincos.sv
module gcd_sincos #(
   parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [gcd_pkg::ANG_W-1:0]      angle,
   output logic                                  out_valid,
   output logic signed [gcd_pkg::CW-1:0]         sin_q30,
   output logic signed [gcd_pkg::CW-1:0]         cos_q30
);
   import gcd_pkg::*;

   // stage R: fold into [-90,90] degrees
   logic signed [RED_W-1:0]     t_red;
   logic signed [RED_OUT_W-1:0] r_in, r_ff;
   logic                        negr_in, negr_ff, vr_ff;

   always_comb begin
      t_red   = RED_W'(angle);
      negr_in = 1'b0;
      if (t_red > HALF_TURN) begin
         t_red = t_red - FULL_TURN;
      end else if (t_red <= -HALF_TURN) begin
         t_red = t_red + FULL_TURN;
      end
      if (t_red > QUARTER_TURN) begin
         t_red   = t_red - HALF_TURN;
         negr_in = 1'b1;
      end else if (t_red < -QUARTER_TURN) begin
         t_red   = t_red + HALF_TURN;
         negr_in = 1'b1;
      end
      r_in = RED_OUT_W'(t_red);
   end

   // stage M: degrees to radians
   logic signed [64:0]   prod;
   logic signed [ZW-1:0] zm_in, zm_ff;
   logic                 negm_ff, vm_ff;

   assign prod  = r_ff * $signed({1'b0, DEG7_TO_RAD_Q31});
   assign zm_in = ZW'(prod >>> 31);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= r_in;
         negr_ff <= negr_in;
         zm_ff   <= zm_in;
         negm_ff <= negr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
         vm_ff <= 1'b0;
      end else if (en) begin
         vr_ff <= in_valid;
         vm_ff <= vr_ff;
      end
   end

   // rotation stages
   logic signed [CW-1:0] x_ff   [STAGES];
   logic signed [CW-1:0] y_ff   [STAGES];
   logic signed [ZW-1:0] z_ff   [STAGES-1];
   logic                 neg_ff [STAGES];
   logic                 vld_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam logic signed [ZW-1:0] ATAN = atan_q30(i);
      logic signed [CW-1:0] x_cur, y_cur;
      logic signed [ZW-1:0] z_cur;
      logic                 neg_cur, vld_cur;

      if (i == 0) begin : g_head
         assign x_cur   = INV_GAIN;
         assign y_cur   = '0;
         assign z_cur   = zm_ff;
         assign neg_cur = negm_ff;
         assign vld_cur = vm_ff;
      end else begin : g_body
         assign x_cur   = x_ff[i-1];
         assign y_cur   = y_ff[i-1];
         assign z_cur   = z_ff[i-1];
         assign neg_cur = neg_ff[i-1];
         assign vld_cur = vld_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i] <= neg_cur;
            if (z_cur >= 0) begin
               x_ff[i] <= x_cur - (y_cur >>> i);
               y_ff[i] <= y_cur + (x_cur >>> i);
            end else begin
               x_ff[i] <= x_cur + (y_cur >>> i);
               y_ff[i] <= y_cur - (x_cur >>> i);
            end
         end
      end

      if (i < STAGES - 1) begin : g_z
         always_ff @(posedge clock) begin
            if (en) begin
               z_ff[i] <= (z_cur >= 0) ? z_cur - ATAN : z_cur + ATAN;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_cur;
         end
      end
   end

   // undo the half-turn fold
   logic signed [CW-1:0] sin_ff, cos_ff;
   logic                 vo_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= neg_ff[STAGES-1] ? -y_ff[STAGES-1] : y_ff[STAGES-1];
         cos_ff <= neg_ff[STAGES-1] ? -x_ff[STAGES-1] : x_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vld_ff[STAGES-1];
      end
   end

   assign out_valid = vo_ff;
   assign sin_q30   = sin_ff;
   assign cos_q30   = cos_ff;

endmodule

### sv/gcd_isqrt.sv
module gcd_isqrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [gcd_pkg::SQ_W-1:0]             radicand,
   input  logic signed [gcd_pkg::DOT_W-1:0]     dot_in,
   output logic                                 out_valid,
   output logic [gcd_pkg::SQRT_W-1:0]           root,
   output logic signed [gcd_pkg::DOT_W-1:0]     dot_out
);
   import gcd_pkg::*;

   // one result bit per stage, two radicand bits consumed per stage
   logic [SQ_W-1:0]         rem_ff [SQ_STEPS-1];
   logic [SQ_W-1:0]         res_ff [SQ_STEPS];
   logic signed [DOT_W-1:0] dot_ff [SQ_STEPS];
   logic                    vld_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
      logic [SQ_W-1:0]         rem_cur, res_cur, rem_nxt, res_nxt;
      logic signed [DOT_W-1:0] dot_cur;
      logic                    vld_cur;
      logic [SQ_W:0]           trial;

      if (k == 0) begin : g_head
         assign rem_cur = radicand;
         assign res_cur = '0;
         assign dot_cur = dot_in;
         assign vld_cur = in_valid;
      end else begin : g_body
         assign rem_cur = rem_ff[k-1];
         assign res_cur = res_ff[k-1];
         assign dot_cur = dot_ff[k-1];
         assign vld_cur = vld_ff[k-1];
      end

      always_comb begin
         trial = {1'b0, res_cur} + {1'b0, BIT};
         if ({1'b0, rem_cur} >= trial) begin
            rem_nxt = SQ_W'({1'b0, rem_cur} - trial);
            res_nxt = (res_cur >> 1) + BIT;
         end else begin
            rem_nxt = rem_cur;
            res_nxt = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[k] <= res_nxt;
            dot_ff[k] <= dot_cur;
         end
      end

      if (k < SQ_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_nxt;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end
   end

   assign out_valid = vld_ff[SQ_STEPS-1];
   assign root      = SQRT_W'(res_ff[SQ_STEPS-1]);
   assign dot_out   = dot_ff[SQ_STEPS-1];

endmodule

### sv/gcd_acos.sv
module gcd_acos #(
   parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [gcd_pkg::SQRT_W-1:0]           sine,
   input  logic signed [gcd_pkg::DOT_W-1:0]     dot,
   output logic                                 out_valid,
   output logic [gcd_pkg::ACOS_W-1:0]           angle
);
   import gcd_pkg::*;

   // vectoring CORDIC on (sqrt(1-c^2), -c), angle accumulated from pi/2
   logic signed [CW-1:0] x_ff   [STAGES-1];
   logic signed [CW-1:0] y_ff   [STAGES-1];
   logic signed [ZW-1:0] z_ff   [STAGES];
   logic                 vld_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_vec
      localparam logic signed [ZW-1:0] ATAN = atan_q30(i);
      logic signed [CW-1:0] x_cur, y_cur;
      logic signed [ZW-1:0] z_cur;
      logic                 vld_cur;

      if (i == 0) begin : g_head
         assign x_cur   = CW'({1'b0, sine});
         assign y_cur   = -(CW'(dot));
         assign z_cur   = HALF_PI_Q30;
         assign vld_cur = in_valid;
      end else begin : g_body
         assign x_cur   = x_ff[i-1];
         assign y_cur   = y_ff[i-1];
         assign z_cur   = z_ff[i-1];
         assign vld_cur = vld_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[i] <= (y_cur < 0) ? z_cur - ATAN : z_cur + ATAN;
         end
      end

      if (i < STAGES - 1) begin : g_xy
         always_ff @(posedge clock) begin
            if (en) begin
               if (y_cur < 0) begin
                  x_ff[i] <= x_cur - (y_cur >>> i);
                  y_ff[i] <= y_cur + (x_cur >>> i);
               end else begin
                  x_ff[i] <= x_cur + (y_cur >>> i);
                  y_ff[i] <= y_cur - (x_cur >>> i);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_cur;
         end
      end
   end

   logic [ACOS_W-1:0] ang_ff;
   logic              vo_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= (z_ff[STAGES-1] < 0) ? '0 : ACOS_W'(z_ff[STAGES-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vld_ff[STAGES-1];
      end
   end

   assign out_valid = vo_ff;
   assign angle     = ang_ff;

endmodule

### sv/great_circle_distance.sv
// Throughput: one position per cycle; the whole pipeline advances together and
// holds while a result sits stalled in the output register.
// Depth is set by the two CORDIC chains and the 32-step square root.
// Reset (synchronous) clears all valid bits and loads the target registers
// with their default position.
module great_circle_distance #(
   parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [gcd_pkg::LAT_W-1:0]     req_cur_lat,
   input  logic signed [gcd_pkg::LON_W-1:0]     req_cur_lon,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gcd_pkg::DIST_W-1:0]           rsp_distance_mm,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  gcd_pkg::csr_index_type               csr_index,
   input  logic [gcd_pkg::CSR_W-1:0]            csr_data
);
   import gcd_pkg::*;

   localparam int PV_W  = 2 * CW;
   localparam int SUM_W = PV_W + 2;
   localparam int PH_W  = 49;
   localparam int MM_W  = DIST_W + 1;

   logic en;
   logic rsp_valid_ff;
   logic [DIST_W-1:0] dist_ff;

   assign en        = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~en;
   assign csr_ready = 1'b1;

   // target registers
   logic signed [LAT_W-1:0] target_lat_ff;
   logic signed [LON_W-1:0] target_lon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_lat_ff <= TARGET_LAT_RST;
         target_lon_ff <= TARGET_LON_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TARGET_LAT: target_lat_ff <= LAT_W'(csr_data);
            CSR_TARGET_LON: target_lon_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // four sine/cosine lanes
   logic signed [CW-1:0] tlat_s, tlat_c, tlon_s, tlon_c;
   logic signed [CW-1:0] clat_s, clat_c, clon_s, clon_c;
   logic                 v_tlat, v_tlon, v_clat, v_clon;

   gcd_sincos #(.STAGES(CORDIC_STAGES)) u_tlat (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .angle(ANG_W'(target_lat_ff)), .out_valid(v_tlat),
      .sin_q30(tlat_s), .cos_q30(tlat_c));

   gcd_sincos #(.STAGES(CORDIC_STAGES)) u_tlon (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .angle(target_lon_ff), .out_valid(v_tlon),
      .sin_q30(tlon_s), .cos_q30(tlon_c));

   gcd_sincos #(.STAGES(CORDIC_STAGES)) u_clat (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .angle(ANG_W'(req_cur_lat)), .out_valid(v_clat),
      .sin_q30(clat_s), .cos_q30(clat_c));

   gcd_sincos #(.STAGES(CORDIC_STAGES)) u_clon (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .angle(req_cur_lon), .out_valid(v_clon),
      .sin_q30(clon_s), .cos_q30(clon_c));

   // unit vectors
   logic signed [PV_W-1:0] ta0_p, ta1_p, cb0_p, cb1_p;
   logic signed [CW-1:0]   a0_ff, a1_ff, a2_ff, b0_ff, b1_ff, b2_ff;
   logic                   vvec_ff;

   assign ta0_p = tlat_c * tlon_c;
   assign ta1_p = tlat_c * tlon_s;
   assign cb0_p = clat_c * clon_c;
   assign cb1_p = clat_c * clon_s;

   // dot product
   logic signed [PV_W-1:0]  p0_ff, p1_ff, p2_ff;
   logic signed [SUM_W-1:0] sum, dsh;
   logic signed [DOT_W-1:0] dot_in, dot_ff;
   logic                    vp_ff, vd_ff;

   always_comb begin
      sum = p0_ff + p1_ff + p2_ff;
      dsh = sum >>> 30;
      if (dsh > SUM_W'(64'sd1073741824)) begin
         dot_in = DOT_W'(64'sd1073741824);
      end else if (dsh < -SUM_W'(64'sd1073741824)) begin
         dot_in = -DOT_W'(64'sd1073741824);
      end else begin
         dot_in = DOT_W'(dsh);
      end
   end

   // radicand 1 - c^2
   logic signed [2*DOT_W-1:0] dsq;
   logic [2*DOT_W-1:0]        nn;
   logic [SQ_W-1:0]           rad_ff;
   logic signed [DOT_W-1:0]   dotq_ff;
   logic                      vq_ff;

   assign dsq = dot_ff * dot_ff;
   assign nn  = (64'd1 << 60) - $unsigned(dsq);

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff   <= CW'(ta0_p >>> 30);
         a1_ff   <= CW'(ta1_p >>> 30);
         a2_ff   <= tlat_s;
         b0_ff   <= CW'(cb0_p >>> 30);
         b1_ff   <= CW'(cb1_p >>> 30);
         b2_ff   <= clat_s;
         p0_ff   <= a0_ff * b0_ff;
         p1_ff   <= a1_ff * b1_ff;
         p2_ff   <= a2_ff * b2_ff;
         dot_ff  <= dot_in;
         rad_ff  <= SQ_W'(nn);
         dotq_ff <= dot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vvec_ff <= 1'b0;
         vp_ff   <= 1'b0;
         vd_ff   <= 1'b0;
         vq_ff   <= 1'b0;
      end else if (en) begin
         vvec_ff <= v_tlat & v_tlon & v_clat & v_clon;
         vp_ff   <= vvec_ff;
         vd_ff   <= vp_ff;
         vq_ff   <= vd_ff;
      end
   end

   logic [SQRT_W-1:0]       root;
   logic signed [DOT_W-1:0] dot_r;
   logic                    v_root;

   gcd_isqrt u_isqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(vq_ff),
      .radicand(rad_ff), .dot_in(dotq_ff),
      .out_valid(v_root), .root(root), .dot_out(dot_r));

   logic [ACOS_W-1:0] ang;
   logic              v_ang;

   gcd_acos #(.STAGES(CORDIC_STAGES)) u_acos (
      .clock(clock), .reset(reset), .en(en), .in_valid(v_root),
      .sine(root), .dot(dot_r), .out_valid(v_ang), .angle(ang));

   // angle times radius, split into 16-bit halves
   logic [PH_W-1:0]  ph_ff, pl_ff;
   logic             vs_ff;
   logic [MM_W-1:0]  mm;
   logic [PH_W:0]    msum;

   assign msum = {1'b0, ph_ff} + {1'b0, (pl_ff >> 16)};
   assign mm   = MM_W'(msum >> 14);

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff <= PH_W'(ang[31:16]) * PH_W'(RADIUS_MM);
         pl_ff <= PH_W'(ang[15:0]) * PH_W'(RADIUS_MM);
         dist_ff <= (mm > {1'b0, HALF_CIRC_MM}) ? HALF_CIRC_MM : DIST_W'(mm);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vs_ff        <= v_ang;
         rsp_valid_ff <= vs_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_mm = dist_ff;

endmodule

### sv/gcd_checker.sv
module gcd_props (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [gcd_pkg::DIST_W-1:0]          rsp_distance_mm
);
   import gcd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_distance_mm))
      else $error("stalled response changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance_mm <= HALF_CIRC_MM)
      else $error("distance above half circumference");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall not tied to blocked output");

endmodule

bind great_circle_distance gcd_props u_gcd_props (.*);
